>>> hw/rtl/rope_pkg.sv
// shared constants, types and helpers for the rotary pair rotate pipeline
package rope_pkg;

  localparam int HALF_W  = 16;
  localparam int MANT_W  = 11;
  localparam int PROD_W  = 22;
  localparam int SHIFT_W = 6;
  localparam int FIX_W   = 81;
  localparam int LZ_W    = 7;
  localparam int TOP_W   = 8;
  localparam int SGL_W   = 24;
  localparam int LANES   = 2;

  localparam logic [HALF_W-1:0] QNAN = 16'h7E00;
  localparam logic [HALF_W-1:0] INF  = 16'h7C00;

  typedef logic [HALF_W-1:0] half_t;

  typedef struct packed {
    logic nan;
    logic inf;
    logic inf_sign;
    logic zero_sign;
  } flags_t;

  typedef struct packed {
    logic              kind_inf;
    logic              kind_nan;
    logic              sgn;
    logic [MANT_W-1:0] mant;
    logic [4:0]        expo;
  } dec_t;

  function automatic dec_t decode(input half_t h);
    dec_t d;
    d.sgn      = h[15];
    d.kind_inf = (h[14:10] == 5'h1f) && (h[9:0] == '0);
    d.kind_nan = (h[14:10] == 5'h1f) && (h[9:0] != '0);
    d.mant     = (h[14:10] == 5'h00) ? {1'b0, h[9:0]} : {1'b1, h[9:0]};
    d.expo     = (h[14:10] == 5'h00) ? 5'd1 : h[14:10];
    return d;
  endfunction

  function automatic logic [LZ_W-1:0] lead_zeros(input logic [FIX_W-1:0] v);
    logic [LZ_W-1:0] n;
    n = '0;
    for (int i = 0; i < FIX_W; i++) begin
      if (v[i]) n = LZ_W'(FIX_W - 1 - i);
    end
    return n;
  endfunction

endpackage

>>> hw/rtl/rope_if.sv
// stream channels for pair inputs and rotated outputs
interface rope_in_if;
  logic                 valid;
  logic                 ready;
  rope_pkg::half_t      x_first;
  rope_pkg::half_t      x_second;
  rope_pkg::half_t      cos_value;
  rope_pkg::half_t      sin_value;
  modport source (output valid, x_first, x_second, cos_value, sin_value, input ready);
  modport sink (input valid, x_first, x_second, cos_value, sin_value, output ready);
endinterface

interface rope_out_if;
  logic                 valid;
  logic                 ready;
  rope_pkg::half_t      y_first;
  rope_pkg::half_t      y_second;
  modport source (output valid, y_first, y_second, input ready);
  modport sink (input valid, y_first, y_second, output ready);
endinterface

>>> hw/rtl/rotary_embedding_pair_rotate.sv
// rotary embedding pair rotate: fp16 products, fp32 sum, fp16 result
// throughput: one pair per cycle while the output is not stalled; the seven-stage pipeline advances as one
// a stall at the output holds every stage in place
// reset clears all stage valid bits; payload registers are not reset
module rotary_embedding_pair_rotate (
  input logic        clk,
  input logic        rst,
  rope_in_if.sink    src,
  rope_out_if.source dst
);

  localparam int L = rope_pkg::LANES;

  logic       en;
  logic [6:0] v;

  // stage 1
  logic [rope_pkg::PROD_W-1:0]  s1_mag [L][2];
  logic [rope_pkg::SHIFT_W-1:0] s1_sh  [L][2];
  logic                         s1_sg  [L][2];
  rope_pkg::flags_t             s1_fl  [L];
  // stage 2
  logic signed [rope_pkg::FIX_W:0] s2_a [L][2];
  rope_pkg::flags_t                s2_fl [L];
  // stage 3
  logic [rope_pkg::FIX_W-1:0] s3_mag [L];
  logic                       s3_neg [L];
  rope_pkg::flags_t           s3_fl  [L];
  // stage 4
  logic [rope_pkg::FIX_W-1:0] s4_mag [L];
  logic [rope_pkg::LZ_W-1:0]  s4_lz  [L];
  logic                       s4_zero[L];
  logic                       s4_neg [L];
  rope_pkg::flags_t           s4_fl  [L];
  // stage 5
  logic [rope_pkg::FIX_W-1:0]       s5_n   [L];
  logic signed [rope_pkg::TOP_W-1:0] s5_top [L];
  logic                             s5_zero[L];
  logic                             s5_neg [L];
  rope_pkg::flags_t                 s5_fl  [L];
  // stage 6
  logic [rope_pkg::SGL_W-1:0]       s6_m   [L];
  logic signed [rope_pkg::TOP_W-1:0] s6_top [L];
  logic                             s6_zero[L];
  logic                             s6_neg [L];
  rope_pkg::flags_t                 s6_fl  [L];
  // stage 7
  rope_pkg::half_t y [L];

  assign en        = !v[6] || dst.ready;
  assign src.ready = en;
  assign dst.valid = v[6];
  assign dst.y_first  = y[0];
  assign dst.y_second = y[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[5:0], src.valid};
    end
  end

  // operand decode and the four products
  rope_pkg::dec_t dx0, dx1, dc, ds;
  logic           neg_t [L][2];

  assign dx0 = rope_pkg::decode(src.x_first);
  assign dx1 = rope_pkg::decode(src.x_second);
  assign dc  = rope_pkg::decode(src.cos_value);
  assign ds  = rope_pkg::decode(src.sin_value);

  always_comb begin
    neg_t[0][0] = 1'b0; neg_t[0][1] = 1'b1;
    neg_t[1][0] = 1'b0; neg_t[1][1] = 1'b0;
  end

  // lane 0 terms: x0*c, x1*s; lane 1 terms: x0*s, x1*c
  rope_pkg::dec_t ta [L][2];
  rope_pkg::dec_t tb [L][2];
  always_comb begin
    ta[0][0] = dx0; tb[0][0] = dc;
    ta[0][1] = dx1; tb[0][1] = ds;
    ta[1][0] = dx0; tb[1][0] = ds;
    ta[1][1] = dx1; tb[1][1] = dc;
  end

  logic p_nan [L][2];
  logic p_inf [L][2];
  logic p_sg  [L][2];
  logic p_zero[L][2];

  always_comb begin
    for (int l = 0; l < L; l++) begin
      for (int k = 0; k < 2; k++) begin
        p_sg[l][k]  = ta[l][k].sgn ^ tb[l][k].sgn ^ neg_t[l][k];
        p_nan[l][k] = ta[l][k].kind_nan || tb[l][k].kind_nan ||
                      (ta[l][k].kind_inf && !tb[l][k].kind_inf && tb[l][k].mant == '0) ||
                      (tb[l][k].kind_inf && !ta[l][k].kind_inf && ta[l][k].mant == '0);
        p_inf[l][k] = !p_nan[l][k] && (ta[l][k].kind_inf || tb[l][k].kind_inf);
        p_zero[l][k] = !ta[l][k].kind_inf && !ta[l][k].kind_nan &&
                       !tb[l][k].kind_inf && !tb[l][k].kind_nan &&
                       (ta[l][k].mant == '0 || tb[l][k].mant == '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < L; l++) begin
        for (int k = 0; k < 2; k++) begin
          s1_mag[l][k] <= (p_inf[l][k] || p_nan[l][k]) ? '0 :
                          ta[l][k].mant * tb[l][k].mant;
          s1_sh[l][k]  <= rope_pkg::SHIFT_W'({1'b0, ta[l][k].expo} + {1'b0, tb[l][k].expo}
                          - 6'd2);
          s1_sg[l][k]  <= p_sg[l][k];
        end
        s1_fl[l].nan  <= p_nan[l][0] || p_nan[l][1] ||
                         (p_inf[l][0] && p_inf[l][1] && (p_sg[l][0] != p_sg[l][1]));
        s1_fl[l].inf  <= p_inf[l][0] || p_inf[l][1];
        s1_fl[l].inf_sign  <= p_inf[l][0] ? p_sg[l][0] : p_sg[l][1];
        s1_fl[l].zero_sign <= p_zero[l][0] && p_zero[l][1] && p_sg[l][0] && p_sg[l][1];
      end
    end
  end

  // align to a common fixed point, lsb weight 2^-48
  logic [rope_pkg::FIX_W-1:0] al [L][2];
  always_comb begin
    for (int l = 0; l < L; l++) begin
      for (int k = 0; k < 2; k++) begin
        al[l][k] = {{(rope_pkg::FIX_W-rope_pkg::PROD_W){1'b0}}, s1_mag[l][k]} << s1_sh[l][k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < L; l++) begin
        for (int k = 0; k < 2; k++) begin
          s2_a[l][k] <= s1_sg[l][k] ? -$signed({1'b0, al[l][k]}) : $signed({1'b0, al[l][k]});
        end
        s2_fl[l] <= s1_fl[l];
      end
    end
  end

  // exact sum and magnitude
  logic signed [rope_pkg::FIX_W+1:0] sum [L];
  logic [rope_pkg::FIX_W+1:0]        absv [L];
  always_comb begin
    for (int l = 0; l < L; l++) begin
      sum[l]  = {s2_a[l][0][rope_pkg::FIX_W], s2_a[l][0]} +
                {s2_a[l][1][rope_pkg::FIX_W], s2_a[l][1]};
      absv[l] = sum[l][rope_pkg::FIX_W+1] ? -sum[l] : sum[l];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < L; l++) begin
        s3_mag[l] <= absv[l][rope_pkg::FIX_W-1:0];
        s3_neg[l] <= sum[l][rope_pkg::FIX_W+1];
        s3_fl[l]  <= s2_fl[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < L; l++) begin
        s4_mag[l]  <= s3_mag[l];
        s4_lz[l]   <= rope_pkg::lead_zeros(s3_mag[l]);
        s4_zero[l] <= s3_mag[l] == '0;
        s4_neg[l]  <= s3_neg[l];
        s4_fl[l]   <= s3_fl[l];
      end
    end
  end

  // normalize, msb weight 2^top
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < L; l++) begin
        s5_n[l]    <= s4_mag[l] << s4_lz[l];
        s5_top[l]  <= rope_pkg::TOP_W'(8'sd32 - $signed({1'b0, s4_lz[l]}));
        s5_zero[l] <= s4_zero[l];
        s5_neg[l]  <= s4_neg[l];
        s5_fl[l]   <= s4_fl[l];
      end
    end
  end

  // round to single precision
  logic [rope_pkg::SGL_W:0] r24 [L];
  always_comb begin
    for (int l = 0; l < L; l++) begin
      r24[l] = {1'b0, s5_n[l][80:57]} +
               (rope_pkg::SGL_W+1)'(s5_n[l][56] && ((|s5_n[l][55:0]) || s5_n[l][57]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < L; l++) begin
        s6_m[l]    <= r24[l][rope_pkg::SGL_W] ? 24'h800000 : r24[l][rope_pkg::SGL_W-1:0];
        s6_top[l]  <= s5_top[l] + rope_pkg::TOP_W'(r24[l][rope_pkg::SGL_W]);
        s6_zero[l] <= s5_zero[l];
        s6_neg[l]  <= s5_neg[l];
        s6_fl[l]   <= s5_fl[l];
      end
    end
  end

  // round to half precision and pack
  logic                              nrm [L];
  logic signed [rope_pkg::TOP_W-1:0] sub_sh [L];
  logic [4:0]                        sh [L];
  logic [49:0]                       ext [L];
  logic [11:0]                       qr [L];
  logic signed [rope_pkg::TOP_W-1:0] e [L];
  rope_pkg::half_t                   pk [L];
  always_comb begin
    for (int l = 0; l < L; l++) begin
      nrm[l]    = s6_top[l] >= -8'sd14;
      sub_sh[l] = -8'sd1 - s6_top[l];
      sh[l]     = nrm[l] ? 5'd13 : ((sub_sh[l] > 8'sd25) ? 5'd25 : sub_sh[l][4:0]);
      ext[l]    = {s6_m[l], 26'b0} >> sh[l];
      qr[l]     = ext[l][37:26] + 12'(ext[l][25] && ((|ext[l][24:0]) || ext[l][26]));
      if (qr[l][11]) begin
        e[l] = s6_top[l] + 8'sd16;
      end else if (nrm[l]) begin
        e[l] = s6_top[l] + 8'sd15;
      end else begin
        e[l] = {7'b0, qr[l][10]};
      end
      if (s6_fl[l].nan) begin
        pk[l] = rope_pkg::QNAN;
      end else if (s6_fl[l].inf) begin
        pk[l] = {s6_fl[l].inf_sign, rope_pkg::INF[14:0]};
      end else if (s6_zero[l]) begin
        pk[l] = {s6_fl[l].zero_sign, 15'b0};
      end else if (e[l] >= 8'sd31) begin
        pk[l] = {s6_neg[l], rope_pkg::INF[14:0]};
      end else begin
        pk[l] = {s6_neg[l], e[l][4:0], qr[l][11] ? 10'b0 : qr[l][9:0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < L; l++) begin
        y[l] <= pk[l];
      end
    end
  end

  a_reset_clears: assert property (@(posedge clk) rst |=> !dst.valid)
    else $error("output valid right after reset");
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (dst.valid && !dst.ready) |=> $stable(v))
    else $error("pipeline moved during stall");
  a_nan_first: assert property (@(posedge clk) disable iff (rst)
    (dst.valid && dst.y_first[14:10] == 5'h1f && dst.y_first[9:0] != 10'h0)
      |-> dst.y_first == rope_pkg::QNAN)
    else $error("non-default nan on first output");
  a_nan_second: assert property (@(posedge clk) disable iff (rst)
    (dst.valid && dst.y_second[14:10] == 5'h1f && dst.y_second[9:0] != 10'h0)
      |-> dst.y_second == rope_pkg::QNAN)
    else $error("non-default nan on second output");

endmodule
